[src/cwcm_pkg.sv]
// Shared types, constants and helper functions for the cylindrical warp
// coordinate map. No dependencies; used by the top level, its checker and the bench.
`timescale 1ns / 1ps

package cwcm_pkg;

   // Field and register widths
   localparam int COORD_W  = 12;
   localparam int DIM_W    = 13;
   localparam int FOCAL_W  = 20;
   localparam int ABS_W    = DIM_W + 1;   // |2*col - W + 2| needs one more bit
   localparam int TH_W     = 17;          // theta, Q1.16 magnitude
   localparam int CORDIC_W = 34;          // Q2.30 plus headroom and sign
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   // Parameter defaults
   localparam int MAX_DIM_DEF         = 4096;
   localparam int FOCAL_FRAC_BITS_DEF = 8;
   localparam int CORDIC_STEPS_DEF    = 16;

   // Register reset values
   localparam logic [FOCAL_W-1:0] FOCAL_RST  = 20'd256000;
   localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;

   localparam logic [TH_W-1:0]            HALF_PI_Q16  = 17'd102944;
   localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

   typedef enum logic [1:0] {
      REG_FOCAL_LENGTH = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2
   } reg_index_type;

   // Sideband carried through the theta divider and the CORDIC
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               xsign;
      logic               ysign;
      logic [ABS_W-1:0]   ayi;
   } thside_type;

   // Sideband carried through the final dividers
   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               xneg;
   } xyside_type;

   // atan(2^-i) in Q2.30
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input int i);
      logic [CORDIC_W-1:0] one_q30;
      one_q30 = 34'd1073741824;
      case (i)
         0:       return 34'sd843314857;
         1:       return 34'sd497837829;
         2:       return 34'sd263043837;
         3:       return 34'sd133525159;
         4:       return 34'sd67021687;
         5:       return 34'sd33543516;
         6:       return 34'sd16775851;
         7:       return 34'sd8388437;
         8:       return 34'sd4194283;
         9:       return 34'sd2097149;
         default: return signed'(one_q30 >> i);
      endcase
   endfunction

   // Quotient width of the final dividers: holds every in-range source offset
   function automatic int quo_width(input int ffb);
      int qx;
      int qy;
      qx = DIM_W + ffb + 8;
      qy = DIM_W + 16;
      return (qx > qy) ? qx : qy;
   endfunction

   // Cycles from the accepting edge to the edge that takes the result
   function automatic int pipe_latency(input int ffb, input int steps);
      return steps + quo_width(ffb) + 24;
   endfunction

endpackage

[src/cylindrical_warp_coordinate_map.sv]
// Top level of the cylindrical warp coordinate map: config registers,
// CORDIC pipeline and output stage. Uses cwcm_pkg and cwcm_div_pipe.
`timescale 1ns / 1ps

// Fully pipelined: a new destination coordinate can be started every clock
// cycle, busy never rises, and each result shows on rsp_* for one cycle with
// rsp_strobe high. The receiver cannot stall; the latency is set mainly by
// the three bit-per-stage dividers (theta, source x, source y) and one
// CORDIC stage per iteration. The user must write the registers through the
// APB port only while no transfer is in flight; the block itself does not
// enforce this.

module cylindrical_warp_coordinate_map #(
   parameter int MAX_DIM         = cwcm_pkg::MAX_DIM_DEF,
   parameter int FOCAL_FRAC_BITS = cwcm_pkg::FOCAL_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = cwcm_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // destination coordinate in
   input  logic                          start,
   output logic                          busy,
   input  logic [cwcm_pkg::COORD_W-1:0]  req_dest_row,
   input  logic [cwcm_pkg::COORD_W-1:0]  req_dest_col,
   // source coordinate out
   output logic                          rsp_strobe,
   output logic [cwcm_pkg::COORD_W-1:0]  rsp_out_row,
   output logic [cwcm_pkg::COORD_W-1:0]  rsp_out_col,
   output logic [cwcm_pkg::COORD_W-1:0]  rsp_src_row,
   output logic [cwcm_pkg::COORD_W-1:0]  rsp_src_col,
   output logic                          rsp_in_bounds,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cwcm_pkg::ADDR_W-1:0]   paddr,
   input  logic [cwcm_pkg::DATA_W-1:0]   pwdata,
   output logic [cwcm_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int COORD_W  = cwcm_pkg::COORD_W;
   localparam int DIM_W    = cwcm_pkg::DIM_W;
   localparam int FOCAL_W  = cwcm_pkg::FOCAL_W;
   localparam int ABS_W    = cwcm_pkg::ABS_W;
   localparam int TH_W     = cwcm_pkg::TH_W;
   localparam int CW       = cwcm_pkg::CORDIC_W;
   localparam int CRD_W    = DIM_W + 3;                  // centred coordinate, halves
   localparam int XFRAC    = FOCAL_FRAC_BITS + 8;
   localparam int TH_SH    = FOCAL_FRAC_BITS + 15;
   localparam int NT_W     = ABS_W + TH_SH + 1;
   localparam int AY_W     = 32;
   localparam int PROD_W   = FOCAL_W + AY_W;
   localparam int NX_W     = PROD_W + 8;
   localparam int NY_W     = ABS_W + 45;
   localparam int DEN_W    = 33;
   localparam int QD       = cwcm_pkg::quo_width(FOCAL_FRAC_BITS);
   localparam int SW       = QD + 2;
   localparam int DIM_CAP  = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
   localparam int THS_W    = $bits(cwcm_pkg::thside_type);
   localparam int XYS_W    = $bits(cwcm_pkg::xyside_type);

   // ---------------------------------------------------------------- registers
   logic [FOCAL_W-1:0] focal_length_ff;
   logic [DIM_W-1:0]   image_width_ff;
   logic [DIM_W-1:0]   image_height_ff;
   logic               csr_write;
   cwcm_pkg::reg_index_type csr_index;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = cwcm_pkg::reg_index_type'(paddr[3:2]);
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_length_ff <= cwcm_pkg::FOCAL_RST;
         image_width_ff  <= cwcm_pkg::WIDTH_RST;
         image_height_ff <= cwcm_pkg::HEIGHT_RST;
      end else if (csr_write) begin
         case (csr_index)
            cwcm_pkg::REG_FOCAL_LENGTH: focal_length_ff <= pwdata[FOCAL_W-1:0];
            cwcm_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[DIM_W-1:0];
            cwcm_pkg::REG_IMAGE_HEIGHT: image_height_ff <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cwcm_pkg::REG_FOCAL_LENGTH: prdata = cwcm_pkg::DATA_W'(focal_length_ff);
         cwcm_pkg::REG_IMAGE_WIDTH:  prdata = cwcm_pkg::DATA_W'(image_width_ff);
         cwcm_pkg::REG_IMAGE_HEIGHT: prdata = cwcm_pkg::DATA_W'(image_height_ff);
         default:                    prdata = '0;
      endcase
   end

   // dimensions above MAX_DIM act as MAX_DIM
   logic [DIM_W-1:0] dim_w;
   logic [DIM_W-1:0] dim_h;

   assign dim_w = (32'(image_width_ff) > MAX_DIM)  ? DIM_W'(DIM_CAP) : image_width_ff;
   assign dim_h = (32'(image_height_ff) > MAX_DIM) ? DIM_W'(DIM_CAP) : image_height_ff;

   // Pipeline never holds off the source.
   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage 1
   // centred coordinates in halves: 2*col - W + 2
   logic               s1_valid_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [CRD_W-1:0]   s1_xi2_ff;
   logic [CRD_W-1:0]   s1_yi2_ff;
   logic [CRD_W-1:0]   xi2_in;
   logic [CRD_W-1:0]   yi2_in;

   assign xi2_in = {3'b000, req_dest_col, 1'b0} - {3'b000, dim_w} + CRD_W'(2);
   assign yi2_in = {3'b000, req_dest_row, 1'b0} - {3'b000, dim_h} + CRD_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff <= req_dest_row;
      s1_col_ff <= req_dest_col;
      s1_xi2_ff <= xi2_in;
      s1_yi2_ff <= yi2_in;
   end

   // ---------------------------------------------------------------- stage 2
   // theta dividend: (|xi2| << (frac + 15)) + f/2, rounds the quotient
   logic                 s2_valid_ff;
   logic [NT_W-1:0]      s2_num_ff;
   cwcm_pkg::thside_type s2_side_ff;
   logic [ABS_W-1:0]     ax_in;
   logic [ABS_W-1:0]     ayi_in;
   logic [NT_W-1:0]      num_theta_in;

   assign ax_in  = s1_xi2_ff[CRD_W-1] ? ABS_W'(-s1_xi2_ff) : s1_xi2_ff[ABS_W-1:0];
   assign ayi_in = s1_yi2_ff[CRD_W-1] ? ABS_W'(-s1_yi2_ff) : s1_yi2_ff[ABS_W-1:0];
   assign num_theta_in = (NT_W'(ax_in) << TH_SH) + NT_W'(focal_length_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_num_ff        <= num_theta_in;
      s2_side_ff.row   <= s1_row_ff;
      s2_side_ff.col   <= s1_col_ff;
      s2_side_ff.xsign <= s1_xi2_ff[CRD_W-1];
      s2_side_ff.ysign <= s1_yi2_ff[CRD_W-1];
      s2_side_ff.ayi   <= ayi_in;
   end

   // ---------------------------------------------------------------- theta = |xi|/f
   // A zero focal length makes the overflow flag rise, so it falls out as out of bounds.
   logic             th_valid;
   logic [TH_W-1:0]  th_quo;
   logic             th_ovf;
   logic [THS_W-1:0] th_side;

   cwcm_div_pipe #(
      .NUM_W  (NT_W),
      .DEN_W  (FOCAL_W),
      .QUO_W  (TH_W),
      .SIDE_W (THS_W)
   ) u_div_theta (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_num    (s2_num_ff),
      .in_den    (focal_length_ff),
      .in_side   (s2_side_ff),
      .out_valid (th_valid),
      .out_quo   (th_quo),
      .out_ovf   (th_ovf),
      .out_side  (th_side)
   );

   // ---------------------------------------------------------------- CORDIC
   // rotation mode, one iteration per stage, gives cos in x and sin in y
   logic                  c_valid_ff [0:CORDIC_STEPS];
   logic                  c_ok_ff    [0:CORDIC_STEPS];
   logic signed [CW-1:0]  cx_ff      [0:CORDIC_STEPS];
   logic signed [CW-1:0]  cy_ff      [0:CORDIC_STEPS];
   logic signed [CW-1:0]  cz_ff      [0:CORDIC_STEPS];
   cwcm_pkg::thside_type  c_side_ff  [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff[0] <= 1'b0;
      end else begin
         c_valid_ff[0] <= th_valid;
      end
   end

   // angle at or past pi/2 is rejected here
   always_ff @(posedge clock) begin
      c_ok_ff[0]   <= !th_ovf && (th_quo < cwcm_pkg::HALF_PI_Q16);
      cx_ff[0]     <= cwcm_pkg::INV_GAIN_Q30;
      cy_ff[0]     <= '0;
      cz_ff[0]     <= signed'(CW'(th_quo) << 14);
      c_side_ff[0] <= cwcm_pkg::thside_type'(th_side);
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [CW-1:0] ATAN_I = cwcm_pkg::atan_q30(i);
      logic z_neg;

      assign z_neg = cz_ff[i][CW-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            c_valid_ff[i+1] <= 1'b0;
         end else begin
            c_valid_ff[i+1] <= c_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         c_ok_ff[i+1]   <= c_ok_ff[i];
         c_side_ff[i+1] <= c_side_ff[i];
         if (z_neg) begin
            cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
            cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
            cz_ff[i+1] <= cz_ff[i] + ATAN_I;
         end else begin
            cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
            cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
            cz_ff[i+1] <= cz_ff[i] - ATAN_I;
         end
      end
   end

   // ---------------------------------------------------------------- stage M
   // f * |sin|, cosine sign check, divider operands
   logic                 m_valid_ff;
   logic                 m_ok_ff;
   logic [PROD_W-1:0]    m_prod_ff;
   logic [DEN_W-1:0]     m_den_ff;
   logic [ABS_W-1:0]     m_ayi_ff;
   cwcm_pkg::xyside_type m_side_ff;
   logic                 m_ysign_ff;
   logic signed [CW-1:0] cx_last;
   logic signed [CW-1:0] cy_last;
   logic                 x_pos;
   logic [AY_W-1:0]      ay_in;
   logic [PROD_W-1:0]    prod_in;

   assign cx_last = cx_ff[CORDIC_STEPS];
   assign cy_last = cy_ff[CORDIC_STEPS];
   assign x_pos   = !cx_last[CW-1] && (cx_last != '0);
   assign ay_in   = cy_last[CW-1] ? AY_W'(-cy_last) : AY_W'(cy_last);
   assign prod_in = focal_length_ff * ay_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= c_valid_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      m_ok_ff        <= c_ok_ff[CORDIC_STEPS] && x_pos;
      m_prod_ff      <= prod_in;
      m_den_ff       <= cx_last[DEN_W-1:0];
      m_ayi_ff       <= c_side_ff[CORDIC_STEPS].ayi;
      m_ysign_ff     <= c_side_ff[CORDIC_STEPS].ysign;
      m_side_ff.ok   <= 1'b0;
      m_side_ff.row  <= c_side_ff[CORDIC_STEPS].row;
      m_side_ff.col  <= c_side_ff[CORDIC_STEPS].col;
      m_side_ff.xneg <= c_side_ff[CORDIC_STEPS].xsign ^ cy_last[CW-1];
   end

   cwcm_pkg::xyside_type dx_side_in;

   always_comb begin
      dx_side_in    = m_side_ff;
      dx_side_in.ok = m_ok_ff;
   end

   // ---------------------------------------------------------------- source x and y
   // |x| = f*|sin|*2^8 / cos,  |y| = |yi2|*2^45 / cos
   logic             dx_valid;
   logic [QD-1:0]    dx_quo;
   logic             dx_ovf;
   logic [XYS_W-1:0] dx_side;
   logic             dy_valid;
   logic [QD-1:0]    dy_quo;
   logic             dy_ovf;
   logic             dy_side;

   cwcm_div_pipe #(
      .NUM_W  (NX_W),
      .DEN_W  (DEN_W),
      .QUO_W  (QD),
      .SIDE_W (XYS_W)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid_ff),
      .in_num    ({m_prod_ff, 8'h00}),
      .in_den    (m_den_ff),
      .in_side   (dx_side_in),
      .out_valid (dx_valid),
      .out_quo   (dx_quo),
      .out_ovf   (dx_ovf),
      .out_side  (dx_side)
   );

   cwcm_div_pipe #(
      .NUM_W  (NY_W),
      .DEN_W  (DEN_W),
      .QUO_W  (QD),
      .SIDE_W (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid_ff),
      .in_num    ({m_ayi_ff, 45'd0}),
      .in_den    (m_den_ff),
      .in_side   (m_ysign_ff),
      .out_valid (dy_valid),
      .out_quo   (dy_quo),
      .out_ovf   (dy_ovf),
      .out_side  (dy_side)
   );

   // ---------------------------------------------------------------- output stage
   // restore the offset, bounds check, floor
   cwcm_pkg::xyside_type f_side;
   logic [SW-1:0]        xs_mag;
   logic [SW-1:0]        ys_mag;
   logic [SW-1:0]        xq;
   logic [SW-1:0]        yq;
   logic                 x_fit;
   logic                 y_fit;
   logic                 ok_in;
   logic                 strobe_in;

   assign f_side = cwcm_pkg::xyside_type'(dx_side);
   assign xs_mag = SW'(dx_quo);
   assign ys_mag = SW'(dy_quo);
   assign xq = (f_side.xneg ? -xs_mag : xs_mag) + (SW'(dim_w) << (XFRAC - 1))
             - (SW'(1) << XFRAC);
   assign yq = (dy_side ? -ys_mag : ys_mag) + (SW'(dim_h) << 15) - (SW'(1) << 16);
   assign x_fit = !xq[SW-1] && (xq[SW-1:XFRAC] < (SW - XFRAC)'(dim_w));
   assign y_fit = !yq[SW-1] && (yq[SW-1:16] < (SW - 16)'(dim_h));
   assign strobe_in = dx_valid && dy_valid;
   assign ok_in = strobe_in && f_side.ok && !dx_ovf && !dy_ovf && x_fit && y_fit;

   logic               rsp_strobe_ff;
   logic               rsp_in_bounds_ff;
   logic [COORD_W-1:0] rsp_out_row_ff;
   logic [COORD_W-1:0] rsp_out_col_ff;
   logic [COORD_W-1:0] rsp_src_row_ff;
   logic [COORD_W-1:0] rsp_src_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff    <= 1'b0;
         rsp_in_bounds_ff <= 1'b0;
      end else begin
         rsp_strobe_ff    <= strobe_in;
         rsp_in_bounds_ff <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_row_ff <= f_side.row;
      rsp_out_col_ff <= f_side.col;
      rsp_src_row_ff <= ok_in ? yq[16+COORD_W-1:16] : '0;
      rsp_src_col_ff <= ok_in ? xq[XFRAC+COORD_W-1:XFRAC] : '0;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_in_bounds = rsp_in_bounds_ff;
   assign rsp_out_row   = rsp_out_row_ff;
   assign rsp_out_col   = rsp_out_col_ff;
   assign rsp_src_row   = rsp_src_row_ff;
   assign rsp_src_col   = rsp_src_col_ff;

endmodule

[src/cwcm_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// and a sideband bus that travels with the data. No package dependency.
`timescale 1ns / 1ps

module cwcm_div_pipe #(
   parameter int NUM_W  = 40,
   parameter int DEN_W  = 20,
   parameter int QUO_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   localparam int HI_W  = NUM_W - QUO_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic              valid_ff [0:QUO_W];
   logic              ovf_ff   [0:QUO_W];
   logic [QUO_W-1:0]  quo_ff   [0:QUO_W];
   logic [SIDE_W-1:0] side_ff  [0:QUO_W];
   logic [DEN_W-1:0]  den_ff   [0:QUO_W-1];
   logic [DEN_W-1:0]  rem_ff   [0:QUO_W-1];
   logic [QUO_W-1:0]  low_ff   [0:QUO_W-1];

   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] den_ext;

   // quotient fits in QUO_W bits only when the high part is below the divisor
   assign hi_ext  = CMP_W'(in_num[NUM_W-1:QUO_W]);
   assign den_ext = CMP_W'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff[0]  <= (hi_ext >= den_ext);
      rem_ff[0]  <= DEN_W'(hi_ext);
      low_ff[0]  <= in_num[QUO_W-1:0];
      quo_ff[0]  <= '0;
      den_ff[0]  <= in_den;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           take;

      assign trial = {rem_ff[k], low_ff[k][QUO_W-1]};
      assign diff  = trial - {1'b0, den_ff[k]};
      assign take  = (trial >= {1'b0, den_ff[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         ovf_ff[k+1]  <= ovf_ff[k];
         quo_ff[k+1]  <= (quo_ff[k] << 1) | QUO_W'(take);
         side_ff[k+1] <= side_ff[k];
      end

      if (k < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_ff[k+1] <= low_ff[k] << 1;
            den_ff[k+1] <= den_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

[src/cwcm_checker.sv]
// Port-level checks for the cylindrical warp coordinate map, bound to the top.
// Uses cwcm_pkg for widths and the pipeline latency.
`timescale 1ns / 1ps

module cwcm_checker #(
   parameter int FOCAL_FRAC_BITS = cwcm_pkg::FOCAL_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = cwcm_pkg::CORDIC_STEPS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [cwcm_pkg::COORD_W-1:0]  rsp_src_row,
   input logic [cwcm_pkg::COORD_W-1:0]  rsp_src_col,
   input logic                          rsp_in_bounds,
   input logic                          pready
);

   localparam int LAT = cwcm_pkg::pipe_latency(FOCAL_FRAC_BITS, CORDIC_STEPS);

   // every result traces back to a start transfer a fixed latency earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without matching start transfer");

   a_black : assert property (@(posedge clock) disable iff (reset)
      !rsp_in_bounds |-> (rsp_src_row == '0 && rsp_src_col == '0))
      else $error("source nonzero while out of bounds");

   a_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_in_bounds |-> rsp_strobe)
      else $error("in_bounds outside a result transfer");

   a_never_stall : assert property (@(posedge clock) disable iff (reset)
      !busy && pready)
      else $error("pipeline or register port stalled");

endmodule

bind cylindrical_warp_coordinate_map cwcm_checker #(
   .FOCAL_FRAC_BITS (FOCAL_FRAC_BITS),
   .CORDIC_STEPS    (CORDIC_STEPS)
) u_cwcm_checker (.*);

[bench/tb_cylindrical_warp_coordinate_map.sv]
// Self-checking bench for cylindrical_warp_coordinate_map: a bit-exact
// predictor of the inverse cylindrical warp checks every result transfer.
// Depends on cwcm_pkg and the top level only.
`timescale 1ns / 1ps

// One mapped coordinate as the block reports it
typedef struct {
   logic [11:0] row;
   logic [11:0] col;
   logic [11:0] src_row;
   logic [11:0] src_col;
   logic        in_bounds;
} warp_result_type;

class warp_scoreboard;
   longint unsigned focal;
   longint unsigned width;
   longint unsigned height;
   warp_result_type pending_q[$];
   int              mismatches;
   int              matched;
   int              in_bounds_seen;

   function new();
      focal  = 256000;
      width  = 640;
      height = 480;
   endfunction

   function longint atan_step(int i);
      longint tab[10];
      tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
              33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return tab[i];
      return (longint'(1) << 30) >> i;
   endfunction

   // Source position of one destination pixel for the current registers
   function warp_result_type map_coord(logic [11:0] row, logic [11:0] col);
      warp_result_type r;
      longint          w, h, xi2, yi2, x, y, z, dx, dy, xm, ym, xq, yq;
      longint unsigned ax, ayi, ay, th;
      bit              ok, xneg;
      w   = (width  > 4096) ? 4096 : longint'(width);
      h   = (height > 4096) ? 4096 : longint'(height);
      xi2 = 2 * longint'(col) - w + 2;
      yi2 = 2 * longint'(row) - h + 2;
      ok  = (focal != 0);
      r.row = row;
      r.col = col;
      r.src_row = 0;
      r.src_col = 0;
      if (ok) begin
         ax = (xi2 < 0) ? -xi2 : xi2;
         th = ((ax << 23) + focal / 2) / focal;
         if (th >= 102944) ok = 0;
      end
      if (ok) begin
         // rotation-mode CORDIC, Q2.30
         x = 652032874;
         y = 0;
         z = longint'(th) << 14;
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_step(i);
            end else begin
               x += dx; y -= dy; z += atan_step(i);
            end
         end
         if (x <= 0) ok = 0;
      end
      if (ok) begin
         ay   = (y < 0) ? -y : y;
         xneg = (xi2 < 0) != (y < 0);
         xm   = ((focal * ay) << 8) / longint'(x);
         ayi  = (yi2 < 0) ? -yi2 : yi2;
         ym   = (ayi << 45) / longint'(x);
         xq   = (xneg ? -xm : xm) + (w << 15) - (longint'(1) << 16);
         yq   = ((yi2 < 0) ? -ym : ym) + (h << 15) - (longint'(1) << 16);
         if (xq >= 0 && yq >= 0 && (xq >>> 16) < w && (yq >>> 16) < h) begin
            r.src_col = 12'(xq >>> 16);
            r.src_row = 12'(yq >>> 16);
         end else begin
            ok = 0;
         end
      end
      r.in_bounds = ok;
      return r;
   endfunction

   function void note_request(logic [11:0] row, logic [11:0] col);
      pending_q = {pending_q, map_coord(row, col)};
   endfunction

   function void check_result(warp_result_type act);
      warp_result_type exp_r;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected result row=%0d col=%0d", act.row, act.col);
         return;
      end
      exp_r = pending_q.pop_front();
      if (act.in_bounds) in_bounds_seen++;
      if (act.row !== exp_r.row || act.col !== exp_r.col ||
          act.src_row !== exp_r.src_row || act.src_col !== exp_r.src_col ||
          act.in_bounds !== exp_r.in_bounds) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp row=%0d col=%0d src=(%0d,%0d) ib=%0b, %s",
                     exp_r.row, exp_r.col, exp_r.src_row, exp_r.src_col,
                     exp_r.in_bounds,
                     $sformatf("got row=%0d col=%0d src=(%0d,%0d) ib=%0b",
                               act.row, act.col, act.src_row, act.src_col,
                               act.in_bounds));
      end else begin
         matched++;
      end
   endfunction
endclass

module tb_cylindrical_warp_coordinate_map;

   localparam int CYCLE_LIMIT = 300000;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [11:0]                    req_dest_row;
   logic [11:0]                    req_dest_col;
   logic                           rsp_strobe;
   logic [11:0]                    rsp_out_row;
   logic [11:0]                    rsp_out_col;
   logic [11:0]                    rsp_src_row;
   logic [11:0]                    rsp_src_col;
   logic                           rsp_in_bounds;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [cwcm_pkg::ADDR_W-1:0]    paddr;
   logic [cwcm_pkg::DATA_W-1:0]    pwdata;
   logic [cwcm_pkg::DATA_W-1:0]    prdata;
   logic                           pready;

   warp_scoreboard coord_board;
   int             cycles;
   int             sent;
   bit             idling_on;

   cylindrical_warp_coordinate_map i_dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_dest_row(req_dest_row), .req_dest_col(req_dest_col),
      .rsp_strobe(rsp_strobe), .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_src_row(rsp_src_row), .rsp_src_col(rsp_src_col),
      .rsp_in_bounds(rsp_in_bounds),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // Watchdog: a stuck handshake or lost results end the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // Monitor: sample at the edge, before any nonblocking update lands.
   // An input transfer is noted for prediction, a strobed result is checked.
   always @(posedge clock) begin
      warp_result_type act;
      if (!reset && start && !busy)
         coord_board.note_request(req_dest_row, req_dest_col);
      if (!reset && rsp_strobe) begin
         act.row       = rsp_out_row;
         act.col       = rsp_out_col;
         act.src_row   = rsp_src_row;
         act.src_col   = rsp_src_col;
         act.in_bounds = rsp_in_bounds;
         coord_board.check_result(act);
      end
   end

   // One coordinate transfer, then maybe a random sender gap.
   // start stays high across back-to-back transfers.
   task automatic send_coord(logic [11:0] row, logic [11:0] col);
      start        <= 1'b1;
      req_dest_row <= row;
      req_dest_col <= col;
      do @(posedge clock); while (busy);
      sent++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Let the pipeline empty so registers change only while idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (coord_board.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; pready is always high
   task automatic write_reg(cwcm_pkg::reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= cwcm_pkg::ADDR_W'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         cwcm_pkg::REG_FOCAL_LENGTH: coord_board.focal  = value & 32'hFFFFF;
         cwcm_pkg::REG_IMAGE_WIDTH:  coord_board.width  = value & 32'h1FFF;
         cwcm_pkg::REG_IMAGE_HEIGHT: coord_board.height = value & 32'h1FFF;
         default: ;
      endcase
   endtask

   task automatic set_geometry(logic [31:0] f, logic [31:0] w, logic [31:0] h);
      drain();
      write_reg(cwcm_pkg::REG_FOCAL_LENGTH, f);
      write_reg(cwcm_pkg::REG_IMAGE_WIDTH, w);
      write_reg(cwcm_pkg::REG_IMAGE_HEIGHT, h);
   endtask

   // Mostly coordinates inside the current frame, where the warp may land in
   // bounds; the rest anywhere in the 12-bit field.
   task automatic random_burst(int count);
      int w;
      int h;
      w = (coord_board.width  > 4096) ? 4096 : int'(coord_board.width);
      h = (coord_board.height > 4096) ? 4096 : int'(coord_board.height);
      repeat (count) begin
         if (w > 0 && h > 0 && $urandom_range(0, 3) != 0)
            send_coord(12'($urandom_range(0, h - 1)), 12'($urandom_range(0, w - 1)));
         else
            send_coord(12'($urandom), 12'($urandom));
      end
   endtask

   initial begin
      coord_board  = new();
      cycles       = 0;
      sent         = 0;
      idling_on    = 1'b1;
      reset        = 1'b1;
      start        = 1'b0;
      req_dest_row = '0;
      req_dest_col = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset geometry, corners, centre, field extremes
      send_coord(12'd0, 12'd0);
      send_coord(12'd479, 12'd639);
      send_coord(12'd239, 12'd319);
      send_coord(12'd0, 12'd639);
      send_coord(12'd4095, 12'd4095);
      send_coord(12'd4095, 12'd0);
      send_coord(12'd0, 12'd4095);
      send_coord(12'hAAA, 12'h555);
      // Shortest focal length: large angles a few columns off centre
      set_geometry(32'd256, 32'd640, 32'd480);
      send_coord(12'd239, 12'd319);
      send_coord(12'd239, 12'd320);
      send_coord(12'd239, 12'd321);
      send_coord(12'd239, 12'd0);
      // Zero focal length never maps in bounds
      set_geometry(32'd0, 32'd640, 32'd480);
      send_coord(12'd239, 12'd319);
      // Zero and oversized dimensions
      set_geometry(32'd256000, 32'd0, 32'd480);
      send_coord(12'd0, 12'd0);
      set_geometry(32'd1048575, 32'd8191, 32'd8191);
      send_coord(12'd0, 12'd0);
      send_coord(12'd4095, 12'd4095);
      send_coord(12'd2047, 12'd2047);
      set_geometry(32'd512, 32'd1, 32'd1);
      send_coord(12'd0, 12'd0);
      send_coord(12'd0, 12'd1);

      // Random phases; the fixed ones after the reset geometry hit the register extremes
      set_geometry(32'd256000, 32'd640, 32'd480);
      random_burst(160);
      set_geometry(32'd1048575, 32'd4096, 32'd4096);
      random_burst(160);
      set_geometry(32'd256, 32'd1, 32'd4096);
      random_burst(120);
      set_geometry(32'd60000, 32'd4096, 32'd1);
      random_burst(120);
      repeat (4) begin
         set_geometry($urandom_range(20000, 700000), $urandom_range(1, 4096),
                      $urandom_range(1, 4096));
         random_burst(140);
      end
      set_geometry($urandom_range(256, 1048575), $urandom_range(0, 8191),
                   $urandom_range(0, 8191));
      random_burst(100);
      // Closing stretch back to back, no gaps
      set_geometry($urandom_range(100000, 400000), $urandom_range(64, 2048),
                   $urandom_range(64, 2048));
      idling_on = 1'b0;
      random_burst(170);

      drain();
      repeat (cwcm_pkg::pipe_latency(cwcm_pkg::FOCAL_FRAC_BITS_DEF,
                                     cwcm_pkg::CORDIC_STEPS_DEF) + 20) @(posedge clock);
      $display("Sent %0d coordinates over 16 geometries; %0d results matched, %0d in bounds",
               sent, coord_board.matched, coord_board.in_bounds_seen);
      $display("Mismatches: %0d, results still owed: %0d",
               coord_board.mismatches, coord_board.pending_q.size());
      if (coord_board.mismatches == 0 && coord_board.pending_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
